// ===== hdl/next_lexicographic_permutation_top_defines.svh =====
// ----------------------------------------------------------------------------
// next_lexicographic_permutation_top_defines.svh
// Assertion macros shared by the permutation block's checker.
// ----------------------------------------------------------------------------
`ifndef NEXT_LEXICOGRAPHIC_PERMUTATION_TOP_DEFINES_SVH
`define NEXT_LEXICOGRAPHIC_PERMUTATION_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define NLP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("permutation block check failed");

// Next-cycle implication, sampled on clk, off during reset
`define NLP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("permutation block check failed");

`endif

// ===== hdl/nlp_pkg.sv =====
// ----------------------------------------------------------------------------
// nlp_pkg
// Types and sizes shared by the next-permutation pipeline.
// ----------------------------------------------------------------------------
package nlp_pkg;

    localparam int NUM_ELEMS  = 8;
    localparam int ELEM_WIDTH = 8;
    // width of the used_count field
    localparam int CNT_W      = 4;
    // position index and saturated count widths
    localparam int IDX_W      = $clog2(NUM_ELEMS);
    localparam int NCNT_W     = $clog2(NUM_ELEMS + 1);
    // room for count + pivot before subtracting the lane index
    localparam int SUM_W      = NCNT_W + 1;

    typedef logic signed [ELEM_WIDTH-1:0] elem_t;
    typedef elem_t elem_arr_t [NUM_ELEMS];

    // rightmost flagged position
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } pick_t;

    // control for the output routing lanes
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] pivot;
        logic [IDX_W-1:0] swp;
    } route_t;

endpackage

// ===== hdl/next_lexicographic_permutation_top.sv =====
// ----------------------------------------------------------------------------
// next_lexicographic_permutation_top
// Lexicographically next arrangement of up to eight signed elements.
// ----------------------------------------------------------------------------
// Input channel: item_valid/item_ready carry elem_0..elem_7 and used_count
// (values above eight act as eight). Output channel: result_valid/
// result_ready carry next_0..next_7 and has_next. One result per transfer.
// Three pipeline stages: rightmost ascent (pivot, seven lanes), rightmost
// element larger than the pivot (eight lanes), each with a merge, then the
// swap/reverse routing (eight lanes) into the output register, which drives
// result_valid; throughput is one item per cycle while nothing stalls.
// Each stage advances when the stage after it is empty or advancing, so a
// stalled receiver holds the output register and the pipeline fills behind
// it; item_ready drops only once all three stages hold items.
// Asynchronous reset (rst_n low) empties all stages; no result is shown
// until new items arrive. Payload registers are not reset.
// Elements beyond used_count pass through; has_next = 0 returns the input.
// ----------------------------------------------------------------------------
module next_lexicographic_permutation_top
    import nlp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic [ELEM_WIDTH-1:0] elem_0,
    input  logic [ELEM_WIDTH-1:0] elem_1,
    input  logic [ELEM_WIDTH-1:0] elem_2,
    input  logic [ELEM_WIDTH-1:0] elem_3,
    input  logic [ELEM_WIDTH-1:0] elem_4,
    input  logic [ELEM_WIDTH-1:0] elem_5,
    input  logic [ELEM_WIDTH-1:0] elem_6,
    input  logic [ELEM_WIDTH-1:0] elem_7,
    input  logic [CNT_W-1:0]      used_count,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic [ELEM_WIDTH-1:0] next_0,
    output logic [ELEM_WIDTH-1:0] next_1,
    output logic [ELEM_WIDTH-1:0] next_2,
    output logic [ELEM_WIDTH-1:0] next_3,
    output logic [ELEM_WIDTH-1:0] next_4,
    output logic [ELEM_WIDTH-1:0] next_5,
    output logic [ELEM_WIDTH-1:0] next_6,
    output logic [ELEM_WIDTH-1:0] next_7,
    output logic                  has_next
);

    elem_arr_t             in_e;
    logic [NCNT_W-1:0]     n_sat;
    logic [NUM_ELEMS-1:0]  asc;
    pick_t                 piv_pick;

    elem_arr_t             s1_e_reg;
    logic [NCNT_W-1:0]     s1_n_reg;
    pick_t                 s1_piv_reg;
    logic                  s1_valid_reg, s1_valid_next;

    elem_t                 piv_val;
    logic [NUM_ELEMS-1:0]  gt;
    pick_t                 swp_pick;

    elem_arr_t             s2_e_reg;
    logic [NCNT_W-1:0]     s2_n_reg;
    route_t                s2_ctl_reg;
    logic                  s2_valid_reg, s2_valid_next;

    elem_arr_t             routed;
    elem_arr_t             out_e_reg;
    logic                  out_has_reg;
    logic                  out_valid_reg, out_valid_next;

    logic                  en1, en2, en3;

    // stage enables: advance into a stage that is empty or moving on
    assign en3        = !out_valid_reg || result_ready;
    assign en2        = !s2_valid_reg || en3;
    assign en1        = !s1_valid_reg || en2;
    assign item_ready = en1;

    // input unpacking and count saturation
    assign in_e[0] = elem_0;
    assign in_e[1] = elem_1;
    assign in_e[2] = elem_2;
    assign in_e[3] = elem_3;
    assign in_e[4] = elem_4;
    assign in_e[5] = elem_5;
    assign in_e[6] = elem_6;
    assign in_e[7] = elem_7;
    assign n_sat   = (used_count > CNT_W'(NUM_ELEMS)) ? NCNT_W'(NUM_ELEMS)
                                                      : NCNT_W'(used_count);

    // stage 1 lanes: ascent at i when e[i] < e[i+1], both inside the count
    genvar gi;
    generate
        for (gi = 0; gi < NUM_ELEMS - 1; gi++)
        begin : g_asc
            nlp_cmp_lane u_asc (
                .a    (in_e[gi+1]),
                .b    (in_e[gi]),
                .en   (NCNT_W'(gi + 1) < n_sat),
                .flag (asc[gi])
            );
        end
    endgenerate
    assign asc[NUM_ELEMS-1] = 1'b0;

    nlp_pick u_piv_pick (
        .flags (asc),
        .pick  (piv_pick)
    );

    // stage 2 lanes: elements after the pivot that beat the pivot value
    assign piv_val = s1_e_reg[s1_piv_reg.idx];

    genvar gj;
    generate
        for (gj = 0; gj < NUM_ELEMS; gj++)
        begin : g_gt
            nlp_cmp_lane u_gt (
                .a    (s1_e_reg[gj]),
                .b    (piv_val),
                .en   (s1_piv_reg.found && (IDX_W'(gj) > s1_piv_reg.idx)
                       && (NCNT_W'(gj) < s1_n_reg)),
                .flag (gt[gj])
            );
        end
    endgenerate

    nlp_pick u_swp_pick (
        .flags (gt),
        .pick  (swp_pick)
    );

    // stage 3 lanes: swap and suffix reversal
    genvar gk;
    generate
        for (gk = 0; gk < NUM_ELEMS; gk++)
        begin : g_route
            nlp_route u_route (
                .lane_idx (IDX_W'(gk)),
                .elems    (s2_e_reg),
                .n        (s2_n_reg),
                .ctl      (s2_ctl_reg),
                .result   (routed[gk])
            );
        end
    endgenerate

    // stage occupancy
    assign s1_valid_next  = en1 ? item_valid   : s1_valid_reg;
    assign s2_valid_next  = en2 ? s1_valid_reg : s2_valid_reg;
    assign out_valid_next = en3 ? s2_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_e_reg   <= in_e;
            s1_n_reg   <= n_sat;
            s1_piv_reg <= piv_pick;
        end
        if (en2)
        begin
            s2_e_reg         <= s1_e_reg;
            s2_n_reg         <= s1_n_reg;
            s2_ctl_reg.found <= s1_piv_reg.found;
            s2_ctl_reg.pivot <= s1_piv_reg.idx;
            s2_ctl_reg.swp   <= swp_pick.idx;
        end
        if (en3)
        begin
            out_e_reg   <= routed;
            out_has_reg <= s2_ctl_reg.found;
        end
    end

    // output ports
    assign result_valid = out_valid_reg;
    assign has_next     = out_has_reg;
    assign next_0       = out_e_reg[0];
    assign next_1       = out_e_reg[1];
    assign next_2       = out_e_reg[2];
    assign next_3       = out_e_reg[3];
    assign next_4       = out_e_reg[4];
    assign next_5       = out_e_reg[5];
    assign next_6       = out_e_reg[6];
    assign next_7       = out_e_reg[7];

endmodule

// ===== hdl/nlp_cmp_lane.sv =====
// ----------------------------------------------------------------------------
// nlp_cmp_lane
// One compare lane: flags a position when it is in range and a > b (signed).
// ----------------------------------------------------------------------------
module nlp_cmp_lane
    import nlp_pkg::*;
(
    input  elem_t a,
    input  elem_t b,
    input  logic  en,
    output logic  flag
);

    // strict signed compare, so equal values never count
    assign flag = en && (a > b);

endmodule

// ===== hdl/nlp_pick.sv =====
// ----------------------------------------------------------------------------
// nlp_pick
// Merge stage: rightmost set flag among the lanes, with a found bit.
// ----------------------------------------------------------------------------
module nlp_pick
    import nlp_pkg::*;
(
    input  logic [NUM_ELEMS-1:0] flags,
    output pick_t                pick
);

    // later positions override earlier ones
    always_comb
    begin
        pick.found = |flags;
        pick.idx   = '0;
        for (int i = 0; i < NUM_ELEMS; i++)
        begin
            if (flags[i])
            begin
                pick.idx = IDX_W'(i);
            end
        end
    end

endmodule

// ===== hdl/nlp_route.sv =====
// ----------------------------------------------------------------------------
// nlp_route
// One output lane: picks the element that lands at this position after the
// pivot swap and the suffix reversal.
// ----------------------------------------------------------------------------
module nlp_route
    import nlp_pkg::*;
(
    input  logic [IDX_W-1:0]  lane_idx,
    input  elem_arr_t         elems,
    input  logic [NCNT_W-1:0] n,
    input  route_t            ctl,
    output elem_t             result
);

    logic             in_sfx;
    logic [SUM_W-1:0] src_sum;
    logic [IDX_W-1:0] src;

    // reversed suffix: position k takes slot n-1-(k-pivot-1) = n+pivot-k
    assign in_sfx  = ctl.found && (lane_idx > ctl.pivot) && (NCNT_W'(lane_idx) < n);
    assign src_sum = SUM_W'(n) + SUM_W'(ctl.pivot) - SUM_W'(lane_idx);
    assign src     = src_sum[IDX_W-1:0];

    // pivot takes the swap element; the swap slot holds the old pivot
    always_comb
    begin
        if (ctl.found && (lane_idx == ctl.pivot))
        begin
            result = elems[ctl.swp];
        end
        else if (in_sfx)
        begin
            result = (src == ctl.swp) ? elems[ctl.pivot] : elems[src];
        end
        else
        begin
            result = elems[lane_idx];
        end
    end

endmodule

// ===== hdl/nlp_checker.sv =====
// ----------------------------------------------------------------------------
// nlp_checker
// Port-level checks on the permutation block, bound to the top level.
// ----------------------------------------------------------------------------
`include "next_lexicographic_permutation_top_defines.svh"

module nlp_checker
    import nlp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_ready,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  logic [ELEM_WIDTH-1:0] next_0,
    input  logic [ELEM_WIDTH-1:0] next_1,
    input  logic [ELEM_WIDTH-1:0] next_2,
    input  logic [ELEM_WIDTH-1:0] next_3,
    input  logic [ELEM_WIDTH-1:0] next_4,
    input  logic [ELEM_WIDTH-1:0] next_5,
    input  logic [ELEM_WIDTH-1:0] next_6,
    input  logic [ELEM_WIDTH-1:0] next_7,
    input  logic                  has_next
);

    // a stalled result stays offered
    `NLP_ASSERT_NEXT(a_res_hold, result_valid && !result_ready, result_valid)

    // a stalled result keeps its payload
    `NLP_ASSERT_NEXT(a_res_stable, result_valid && !result_ready,
        $stable(has_next) && $stable(next_0) && $stable(next_1) && $stable(next_2)
        && $stable(next_3) && $stable(next_4) && $stable(next_5) && $stable(next_6)
        && $stable(next_7))

    // with no result waiting the pipeline cannot be full
    `NLP_ASSERT_NOW(a_ready_when_empty, !result_valid, item_ready)

    // an accepted item passes stage 1 and stage 2 into the output register while result_ready holds
    `NLP_ASSERT_NEXT(a_latency,
        (item_valid && item_ready) ##1 result_ready ##1 result_ready, result_valid)

endmodule

bind next_lexicographic_permutation_top nlp_checker u_nlp_checker (.*);
